// ===== hdl/uartrx_pkg.sv =====
// ----------------------------------------------------------------------------
// uartrx_pkg
// Shared types and constants for the UART RX FIFO / IRQ register block.
// ----------------------------------------------------------------------------
package uartrx_pkg;

    // Default receive FIFO depth
    localparam int RX_DEPTH_DEF = 16;

    // Field widths
    localparam int OFFSET_W = 12;
    localparam int DATA_W   = 11;
    localparam int BYTE_W   = 8;

    // Register byte offsets (PL011 layout)
    localparam logic [OFFSET_W-1:0] OFF_DR   = 12'h000;
    localparam logic [OFFSET_W-1:0] OFF_FR   = 12'h018;
    localparam logic [OFFSET_W-1:0] OFF_IMSC = 12'h038;
    localparam logic [OFFSET_W-1:0] OFF_RIS  = 12'h03C;
    localparam logic [OFFSET_W-1:0] OFF_MIS  = 12'h040;
    localparam logic [OFFSET_W-1:0] OFF_ICR  = 12'h044;

    // Bit positions
    localparam int RX_BIT  = 4;
    localparam int FR_RXFE = 4;
    localparam int FR_RXFF = 6;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RX    = 2'd2
    } opcode_t;

    // FIFO status seen by the register decode
    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

    // Result word held between decode and the output register
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              use_pop;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              irq_pulse;
        logic              rx_accepted;
    } stage_t;

endpackage

// ===== hdl/uartrx_fifo.sv =====
// ----------------------------------------------------------------------------
// uartrx_fifo
// Receive FIFO: circular buffer in a synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module uartrx_fifo #(
    parameter int RX_DEPTH = uartrx_pkg::RX_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic [uartrx_pkg::BYTE_W-1:0]   push_data,
    input  logic                            pop,
    output logic [uartrx_pkg::BYTE_W-1:0]   pop_data,
    output uartrx_pkg::fifo_status_t        status
);

    localparam int PW = $clog2(RX_DEPTH);
    localparam int CW = $clog2(RX_DEPTH + 1);

    logic [uartrx_pkg::BYTE_W-1:0] mem [RX_DEPTH];

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [uartrx_pkg::BYTE_W-1:0] rdata_reg;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CW'(RX_DEPTH));
    assign pop_data     = rdata_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next  = (tail_reg == PW'(RX_DEPTH - 1)) ? '0 : tail_reg + PW'(1);
            count_next = count_reg + CW'(1);
        end
        else if (pop)
        begin
            head_next  = (head_reg == PW'(RX_DEPTH - 1)) ? '0 : head_reg + PW'(1);
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // push and pop never share a cycle, so no bypass is needed
    always_ff @(posedge clk)
    begin
        if (push)
            mem[tail_reg] <= push_data;
        if (pop)
            rdata_reg <= mem[head_reg];
    end

endmodule

// ===== hdl/uart_rx_fifo_irq_registers.sv =====
// ----------------------------------------------------------------------------
// uart_rx_fifo_irq_registers
// Minimal PL011-style register block with receive FIFO and RX interrupt.
// ----------------------------------------------------------------------------
// One word in per cycle, one result word out per cycle. Each input word is a
// register read, a register write or an arriving receive byte, and gives one
// result word, which passes through the decode stage and then the output
// register. The output register is needed by the receive FIFO RAM, whose
// read port is registered: a DR read issues the RAM read at acceptance and
// the popped byte joins the result in the following stage. in_ready stays
// high while the output register is free or being emptied, so full rate is
// kept as long as out_ready is held high. FIFO RAM contents are not reset;
// only entries that have been pushed are ever read back. Register offsets
// and bit positions follow the PL011 layout; only the RX interrupt (bit 4)
// is implemented, other offsets read 0 and ignore writes.
// ----------------------------------------------------------------------------
module uart_rx_fifo_irq_registers #(
    parameter int RX_DEPTH = uartrx_pkg::RX_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        opcode,
    input  logic [uartrx_pkg::OFFSET_W-1:0]   reg_offset,
    input  logic [uartrx_pkg::DATA_W-1:0]     write_data,
    input  logic [uartrx_pkg::BYTE_W-1:0]     rx_byte,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [uartrx_pkg::DATA_W-1:0]     read_data,
    output logic                              tx_valid,
    output logic [uartrx_pkg::BYTE_W-1:0]     tx_byte,
    output logic                              irq_pulse,
    output logic                              rx_accepted
);

    localparam int DW = uartrx_pkg::DATA_W;
    localparam int BW = uartrx_pkg::BYTE_W;

    // ---------------------------------------------------------------------
    // Handshake: decode stage s1 feeds the output register.
    // ---------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;      // output register can load this cycle
    logic accept;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_free;
    assign accept   = in_valid && in_ready;

    // ---------------------------------------------------------------------
    // Architectural registers. Only RX raw status (bit 4) can ever be set,
    // so it is kept as a single flop.
    // ---------------------------------------------------------------------
    logic          rx_raw_reg, rx_raw_next;
    logic [DW-1:0] int_mask_reg, int_mask_next;

    // FIFO interface
    logic                     fifo_push;
    logic                     fifo_pop;
    logic [BW-1:0]            fifo_pop_data;
    uartrx_pkg::fifo_status_t fifo_status;

    uartrx_fifo #(
        .RX_DEPTH (RX_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (rx_byte),
        .pop       (fifo_pop),
        .pop_data  (fifo_pop_data),
        .status    (fifo_status)
    );

    // ---------------------------------------------------------------------
    // Decode: computes the result word and register updates for the word
    // being accepted. A DR read only flags the pop; the byte arrives from
    // the RAM's registered read port while the word is held in s1.
    // ---------------------------------------------------------------------
    uartrx_pkg::stage_t s1_next;
    uartrx_pkg::stage_t s1_reg;
    logic [DW-1:0]      raw_word;

    assign raw_word = DW'(rx_raw_reg) << uartrx_pkg::RX_BIT;

    always_comb
    begin
        s1_next       = '0;
        rx_raw_next   = rx_raw_reg;
        int_mask_next = int_mask_reg;
        fifo_push     = 1'b0;
        fifo_pop      = 1'b0;

        if (accept)
        begin
            case (opcode)
                uartrx_pkg::OP_READ:
                begin
                    case (reg_offset)
                        uartrx_pkg::OFF_DR:
                        begin
                            rx_raw_next      = 1'b0;
                            fifo_pop         = !fifo_status.empty;
                            s1_next.use_pop  = !fifo_status.empty;
                        end
                        uartrx_pkg::OFF_FR:
                        begin
                            if (fifo_status.empty)
                                s1_next.read_data[uartrx_pkg::FR_RXFE] = 1'b1;
                            else
                                s1_next.read_data[uartrx_pkg::FR_RXFF] = 1'b1;
                        end
                        uartrx_pkg::OFF_IMSC: s1_next.read_data = int_mask_reg;
                        uartrx_pkg::OFF_RIS:  s1_next.read_data = raw_word;
                        uartrx_pkg::OFF_MIS:  s1_next.read_data = raw_word & int_mask_reg;
                        default:              s1_next.read_data = '0;
                    endcase
                end
                uartrx_pkg::OP_WRITE:
                begin
                    case (reg_offset)
                        uartrx_pkg::OFF_DR:
                        begin
                            s1_next.tx_valid = 1'b1;
                            s1_next.tx_byte  = write_data[BW-1:0];
                        end
                        uartrx_pkg::OFF_IMSC:
                        begin
                            // pulse on a fresh unmask of a pending RX
                            s1_next.irq_pulse = write_data[uartrx_pkg::RX_BIT]
                                && !int_mask_reg[uartrx_pkg::RX_BIT] && rx_raw_reg;
                            int_mask_next = write_data;
                        end
                        uartrx_pkg::OFF_ICR:
                        begin
                            if (write_data[uartrx_pkg::RX_BIT])
                                rx_raw_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                uartrx_pkg::OP_RX:
                begin
                    // raw bit and irq are set even when the byte is dropped
                    fifo_push           = !fifo_status.full;
                    s1_next.rx_accepted = !fifo_status.full;
                    rx_raw_next         = 1'b1;
                    s1_next.irq_pulse   = int_mask_reg[uartrx_pkg::RX_BIT];
                end
                default:
                begin
                end
            endcase
        end
    end

    // stage valid bits
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = s1_valid_reg;
        if (in_ready)
            s1_valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rx_raw_reg    <= 1'b0;
            int_mask_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            rx_raw_reg    <= rx_raw_next;
            int_mask_reg  <= int_mask_next;
        end
    end

    // ---------------------------------------------------------------------
    // Payload registers. s1 holds while stalled; the RAM read register also
    // holds since no new pop can be issued until s1 moves on.
    // ---------------------------------------------------------------------
    logic [DW-1:0] read_data_reg;
    logic          tx_valid_reg;
    logic [BW-1:0] tx_byte_reg;
    logic          irq_pulse_reg;
    logic          rx_accepted_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
        if (out_free && s1_valid_reg)
        begin
            read_data_reg   <= s1_reg.use_pop ? DW'(fifo_pop_data) : s1_reg.read_data;
            tx_valid_reg    <= s1_reg.tx_valid;
            tx_byte_reg     <= s1_reg.tx_byte;
            irq_pulse_reg   <= s1_reg.irq_pulse;
            rx_accepted_reg <= s1_reg.rx_accepted;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign tx_valid    = tx_valid_reg;
    assign tx_byte     = tx_byte_reg;
    assign irq_pulse   = irq_pulse_reg;
    assign rx_accepted = rx_accepted_reg;

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UART RX FIFO / IRQ register block.
// ----------------------------------------------------------------------------
// Register reads, register writes and arriving receive bytes go in through
// the valid/ready input channel. A scoreboard keeps its own copy of the FIFO,
// raw status and mask. It works out the result word of every accepted input
// word and checks each accepted result word against the oldest one it holds.
// Both sides idle at random. Once, the sink holds off for a long stretch
// while bytes keep arriving, so the pipe fills and the FIFO overflows. The
// source also stops from time to time until every result word is back.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFFSET_W     = uartrx_pkg::OFFSET_W;
    localparam int DATA_W       = uartrx_pkg::DATA_W;
    localparam int BYTE_W       = uartrx_pkg::BYTE_W;
    localparam int RX_DEPTH_DEF = uartrx_pkg::RX_DEPTH_DEF;

    // opcode 3 has no meaning; the block must answer it with an all-zero word
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [DATA_W-1:0] RX_MASK   = DATA_W'(1) << uartrx_pkg::RX_BIT;
    localparam logic [DATA_W-1:0] FR_EMPTY  = DATA_W'(1) << uartrx_pkg::FR_RXFE;
    localparam logic [DATA_W-1:0] FR_HOLDS  = DATA_W'(1) << uartrx_pkg::FR_RXFF;

    localparam int RANDOM_WORDS = 1700;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_EVERY  = 300;
    localparam int TAIL_CYCLES  = 10;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              irq_pulse;
        logic              rx_accepted;
    } uart_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow register state plus the queue of result words still
    // owed by the block.
    // ------------------------------------------------------------------------
    class uart_reg_scoreboard;
        logic [BYTE_W-1:0] rx_store [RX_DEPTH_DEF];
        int unsigned       pop_idx;
        int unsigned       push_idx;
        int unsigned       held;
        logic [DATA_W-1:0] ris_bits;
        logic [DATA_W-1:0] imsc_bits;
        uart_result_t      owed_results [$];
        int unsigned       mismatches;

        function new();
            pop_idx    = 0;
            push_idx   = 0;
            held       = 0;
            ris_bits   = '0;
            imsc_bits  = '0;
            mismatches = 0;
        endfunction

        // Accepted input word: advance the shadow state, queue its result.
        function void note_request(input logic [1:0]          op,
                                   input logic [OFFSET_W-1:0] off,
                                   input logic [DATA_W-1:0]   wd,
                                   input logic [BYTE_W-1:0]   rb);
            uart_result_t r;
            r = '0;
            case (op)
                uartrx_pkg::OP_READ:
                begin
                    case (off)
                        uartrx_pkg::OFF_DR:
                        begin
                            ris_bits &= ~RX_MASK;
                            if (held != 0)
                            begin
                                r.read_data = DATA_W'(rx_store[pop_idx]);
                                pop_idx     = (pop_idx + 1) % RX_DEPTH_DEF;
                                held--;
                            end
                        end
                        uartrx_pkg::OFF_FR:
                            r.read_data = (held == 0) ? FR_EMPTY : FR_HOLDS;
                        uartrx_pkg::OFF_IMSC: r.read_data = imsc_bits;
                        uartrx_pkg::OFF_RIS:  r.read_data = ris_bits;
                        uartrx_pkg::OFF_MIS:  r.read_data = ris_bits & imsc_bits;
                        default:              r.read_data = '0;
                    endcase
                end
                uartrx_pkg::OP_WRITE:
                begin
                    case (off)
                        uartrx_pkg::OFF_DR:
                        begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = wd[BYTE_W-1:0];
                        end
                        uartrx_pkg::OFF_IMSC:
                        begin
                            r.irq_pulse = wd[uartrx_pkg::RX_BIT]
                                          && !imsc_bits[uartrx_pkg::RX_BIT]
                                          && ris_bits[uartrx_pkg::RX_BIT];
                            imsc_bits   = wd;
                        end
                        uartrx_pkg::OFF_ICR:  ris_bits &= ~wd;
                        default: ;
                    endcase
                end
                uartrx_pkg::OP_RX:
                begin
                    if (held < RX_DEPTH_DEF)
                    begin
                        rx_store[push_idx] = rb;
                        push_idx           = (push_idx + 1) % RX_DEPTH_DEF;
                        held++;
                        r.rx_accepted      = 1'b1;
                    end
                    // raw bit and irq follow the arrival even when it is dropped
                    ris_bits   |= RX_MASK;
                    r.irq_pulse = imsc_bits[uartrx_pkg::RX_BIT];
                end
                default: ;
            endcase
            owed_results.push_back(r);
        endfunction

        function void check_response(input uart_result_t got);
            uart_result_t exp_r;
            if (owed_results.size() == 0)
            begin
                $error("result word with nothing owed: %h", got);
                mismatches++;
                return;
            end
            exp_r = owed_results.pop_front();
            if (got.read_data !== exp_r.read_data)
            begin
                $error("read_data: expected %0h, got %0h", exp_r.read_data, got.read_data);
                mismatches++;
            end
            if (got.tx_valid !== exp_r.tx_valid)
            begin
                $error("tx_valid: expected %0b, got %0b", exp_r.tx_valid, got.tx_valid);
                mismatches++;
            end
            if (got.tx_byte !== exp_r.tx_byte)
            begin
                $error("tx_byte: expected %0h, got %0h", exp_r.tx_byte, got.tx_byte);
                mismatches++;
            end
            if (got.irq_pulse !== exp_r.irq_pulse)
            begin
                $error("irq_pulse: expected %0b, got %0b", exp_r.irq_pulse, got.irq_pulse);
                mismatches++;
            end
            if (got.rx_accepted !== exp_r.rx_accepted)
            begin
                $error("rx_accepted: expected %0b, got %0b",
                       exp_r.rx_accepted, got.rx_accepted);
                mismatches++;
            end
        endfunction

        function int unsigned owed();
            return owed_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          opcode;
    logic [OFFSET_W-1:0] reg_offset;
    logic [DATA_W-1:0]   write_data;
    logic [BYTE_W-1:0]   rx_byte;
    logic                out_valid;
    logic                out_ready;
    logic [DATA_W-1:0]   read_data;
    logic                tx_valid;
    logic [BYTE_W-1:0]   tx_byte;
    logic                irq_pulse;
    logic                rx_accepted;

    uart_rx_fifo_irq_registers i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .reg_offset  (reg_offset),
        .write_data  (write_data),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .tx_valid    (tx_valid),
        .tx_byte     (tx_byte),
        .irq_pulse   (irq_pulse),
        .rx_accepted (rx_accepted)
    );

    uart_reg_scoreboard sb = new();

    // Idle control shared between the stimulus and the sink process.
    bit          source_steady = 1'b0;  // no gaps on the input side
    bit          sink_steady   = 1'b0;  // no stalls on the output side
    bit          hold_request  = 1'b0;  // ask the sink for one long hold-off
    int unsigned words_sent    = 0;
    int unsigned ignored_words = 0;

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // Monitors: both sample at the rising edge, where every bench-driven
    // signal still holds its pre-edge value (all driving is nonblocking).
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_request(opcode, reg_offset, write_data, rx_byte);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_response({read_data, tx_valid, tx_byte, irq_pulse, rx_accepted});
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sink: random stall before each result word, steady stretches, and the
    // one long hold-off counted here when the stimulus asks for it.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else if (sink_steady)
            begin
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, 9);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
            if (taken % 64 == 0)
                sink_steady = ($urandom_range(0, 2) == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------------

    // Offer one word and hold it until taken. valid is left high afterwards so
    // a back-to-back word never sees valid dropped and raised in one step.
    task automatic send_word(input logic [1:0]          op,
                             input logic [OFFSET_W-1:0] off,
                             input logic [DATA_W-1:0]   wd,
                             input logic [BYTE_W-1:0]   rb);
        int unsigned gap;
        gap = source_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        reg_offset <= off;
        write_data <= wd;
        rx_byte    <= rb;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    // Stop offering until every owed result word has come back. The first
    // edge lets the input monitor log the word accepted just before.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.owed() != 0) @(posedge clk);
    endtask

    // Mostly decoded offsets, plus aliases that differ in one bit and noise.
    function automatic logic [OFFSET_W-1:0] pick_offset();
        logic [OFFSET_W-1:0] known [6];
        logic [OFFSET_W-1:0] base;
        known = '{uartrx_pkg::OFF_DR, uartrx_pkg::OFF_FR, uartrx_pkg::OFF_IMSC,
                  uartrx_pkg::OFF_RIS, uartrx_pkg::OFF_MIS, uartrx_pkg::OFF_ICR};
        base  = known[$urandom_range(0, 5)];
        case ($urandom_range(0, 9))
            6:       return base | (OFFSET_W'(1) << $urandom_range(7, 11));
            7:       return base ^ (OFFSET_W'(1) << $urandom_range(0, 6));
            8:       return OFFSET_W'($urandom_range(0, 4095));
            9:       return '1;
            default: return base;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_data();
        return DATA_W'($urandom_range(0, 2047));
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // One random sequence; most are well-formed register traffic.
    task automatic run_sequence();
        int unsigned n;
        logic [DATA_W-1:0] mask_val;
        n = $urandom_range(1, 20);
        source_steady = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 9))
            0, 1:
            begin
                // burst of arrivals, long ones overflow the FIFO
                repeat (n)
                    send_word(uartrx_pkg::OP_RX, pick_offset(), rand_data(), rand_byte());
            end
            2, 3:
            begin
                // software draining the FIFO, polling FR now and then
                repeat (n)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_word(uartrx_pkg::OP_READ, uartrx_pkg::OFF_FR, rand_data(),
                                  rand_byte());
                    send_word(uartrx_pkg::OP_READ, uartrx_pkg::OFF_DR, rand_data(),
                              rand_byte());
                end
            end
            4:
            begin
                // mask update, bit 4 toggled half the time, then status readback
                mask_val = rand_data();
                send_word(uartrx_pkg::OP_WRITE, uartrx_pkg::OFF_IMSC, mask_val, rand_byte());
                send_word(uartrx_pkg::OP_READ, uartrx_pkg::OFF_MIS, rand_data(), rand_byte());
                send_word(uartrx_pkg::OP_READ, uartrx_pkg::OFF_RIS, rand_data(), rand_byte());
                send_word(uartrx_pkg::OP_READ, uartrx_pkg::OFF_IMSC, rand_data(), rand_byte());
            end
            5:
            begin
                send_word(uartrx_pkg::OP_WRITE, uartrx_pkg::OFF_ICR, rand_data(), rand_byte());
                send_word(uartrx_pkg::OP_READ, uartrx_pkg::OFF_RIS, rand_data(), rand_byte());
            end
            6:
            begin
                repeat (n)
                    send_word(uartrx_pkg::OP_WRITE, uartrx_pkg::OFF_DR, rand_data(),
                              rand_byte());
            end
            7:
            begin
                // raw noise, mostly hitting unused offsets
                n = $urandom_range(1, 6);
                repeat (n)
                    send_word(2'($urandom_range(0, 3)), OFFSET_W'($urandom_range(0, 4095)),
                              rand_data(), rand_byte());
                ignored_words += n;
            end
            8:
            begin
                repeat (n)
                    send_word(2'($urandom_range(0, 1)), pick_offset(), rand_data(),
                              rand_byte());
            end
            default:
            begin
                // receive and read interleaved
                repeat (n)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_word(uartrx_pkg::OP_RX, pick_offset(), rand_data(),
                                  rand_byte());
                    else
                        send_word(uartrx_pkg::OP_READ, uartrx_pkg::OFF_DR, rand_data(),
                                  rand_byte());
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned next_drain;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        opcode     <= uartrx_pkg::OP_READ;
        reg_offset <= '0;
        write_data <= '0;
        rx_byte    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every register both ways, field extremes, special cases.
        send_word(uartrx_pkg::OP_READ,  uartrx_pkg::OFF_FR,   '0, '0);  // empty flag
        send_word(uartrx_pkg::OP_READ,  uartrx_pkg::OFF_DR,   '0, '0);  // empty pop is 0
        send_word(uartrx_pkg::OP_READ,  uartrx_pkg::OFF_IMSC, '1, '1);
        send_word(uartrx_pkg::OP_READ,  uartrx_pkg::OFF_RIS,  '0, '0);
        send_word(uartrx_pkg::OP_READ,  uartrx_pkg::OFF_MIS,  '0, '0);
        send_word(uartrx_pkg::OP_READ,  uartrx_pkg::OFF_ICR,  '1, '1);  // write-only
        send_word(uartrx_pkg::OP_READ,  '1,                   '1, '1);  // unknown offset
        send_word(uartrx_pkg::OP_WRITE, uartrx_pkg::OFF_DR,   '1, '0);  // tx byte 0xFF
        send_word(uartrx_pkg::OP_WRITE, uartrx_pkg::OFF_DR,   '0, '1);  // tx byte 0x00
        send_word(uartrx_pkg::OP_WRITE, uartrx_pkg::OFF_IMSC, RX_MASK, '0);  // unmask
        send_word(uartrx_pkg::OP_RX,    '0,                   '0, '1);  // arrival irq
        send_word(uartrx_pkg::OP_RX,    '1,                   '1, '0);
        send_word(uartrx_pkg::OP_WRITE, uartrx_pkg::OFF_IMSC, '0, '0);
        send_word(uartrx_pkg::OP_WRITE, uartrx_pkg::OFF_IMSC, '1, '0);  // unmask, pending
        send_word(uartrx_pkg::OP_READ,  uartrx_pkg::OFF_MIS,  '0, '0);
        send_word(uartrx_pkg::OP_READ,  uartrx_pkg::OFF_FR,   '0, '0);  // FIFO holds data
        send_word(uartrx_pkg::OP_WRITE, uartrx_pkg::OFF_FR,   '1, '1);  // read-only
        send_word(uartrx_pkg::OP_WRITE, uartrx_pkg::OFF_RIS,  '1, '1);
        send_word(uartrx_pkg::OP_WRITE, uartrx_pkg::OFF_MIS,  '1, '1);
        send_word(uartrx_pkg::OP_WRITE, '1,                   '1, '1);  // unknown offset
        send_word(uartrx_pkg::OP_WRITE, uartrx_pkg::OFF_ICR,  '1, '0);  // clear all
        send_word(uartrx_pkg::OP_READ,  uartrx_pkg::OFF_RIS,  '0, '0);
        send_word(OP_UNUSED,            uartrx_pkg::OFF_DR,   '1, '1);  // unused opcode
        send_word(uartrx_pkg::OP_READ,  uartrx_pkg::OFF_DR,   '0, '0);
        wait_results_drained();

        // Long sink hold-off while arrivals keep coming: the pipe backs up,
        // in_ready drops, and the FIFO overflows once it is released.
        hold_request  = 1'b1;
        source_steady = 1'b1;
        repeat (24) send_word(uartrx_pkg::OP_RX, pick_offset(), rand_data(), rand_byte());
        source_steady = 1'b0;
        wait_results_drained();

        // Random part, with a full drain now and then.
        words_sent = 0;
        next_drain = DRAIN_EVERY;
        while (words_sent < RANDOM_WORDS + ignored_words)
        begin
            run_sequence();
            if (words_sent >= next_drain)
            begin
                wait_results_drained();
                next_drain += DRAIN_EVERY;
            end
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.owed() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
